>>> hw/rtl/dvt_pkg.sv
// package for the detection vote table
// table geometry, derived widths, result codes and shared types
// no dependencies
package dvt_pkg;

	// table geometry
	localparam int TABLE_SLOTS = 16;
	localparam int COORD_BITS  = 12;

	// fixed field widths
	localparam int IN_COORD_W = 12;
	localparam int RADIUS_W   = 16;
	localparam int VOTE_W     = 16;
	localparam int SLOT_OUT_W = 4;

	// derived widths
	localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
	localparam int CMP_W  = ((COORD_BITS + 4 > RADIUS_W) ? COORD_BITS + 4 : RADIUS_W) + 1;

	localparam logic [VOTE_W-1:0] VOTE_MAX       = '1;
	localparam logic [VOTE_W-1:0] THRESHOLD_INIT = VOTE_W'(50);
	localparam logic [CNT_W-1:0]  CNT_FULL       = CNT_W'(TABLE_SLOTS);

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [RADIUS_W-1:0]   radius_t;
	typedef logic [VOTE_W-1:0]     vote_t;
	typedef logic [SLOT_W-1:0]     slot_idx_t;
	typedef logic [CNT_W-1:0]      count_t;

	// result codes
	typedef enum logic [1:0] {
		OUTCOME_VOTED   = 2'd0,
		OUTCOME_ADDED   = 2'd1,
		OUTCOME_DROPPED = 2'd2
	} outcome_t;

	// match search result
	typedef struct packed {
		logic      hit;
		slot_idx_t idx;
	} match_t;

endpackage

>>> hw/rtl/detection_vote_table_top.sv
// detection vote table top level: input register, table, update and result register
// depends on dvt_pkg and dvt_match
//
// Usage:
//   in channel: one detected circle per word (center_x, center_y, radius_q4),
//   taken at a rising edge with in_valid high and in_stall low.
//   out channel: one result word per detection (slot, outcome, vote_after,
//   confirmed), taken at a rising edge with out_valid high and out_stall low.
//   cfg channel: cfg_data writes confirm_threshold when cfg_valid and
//   cfg_ready are high; cfg_ready is always high. Write only while idle.
// Path: a detection taken is held in the input register; its result is
//   loaded into the output register when out_free is high and is offered from then.
// Throughput: one detection per cycle while the output is not stalled. The table
//   compare of all entries, the priority pick and the entry update all lie
//   between the input register and the output register.
// Reset: table emptied (entry count zero), threshold back to 50, both
//   pipeline registers empty.
// Stall: a held result keeps the output register; the input register still
//   takes one more detection, then in_stall rises until out_stall drops.
module detection_vote_table_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// detection input
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [dvt_pkg::IN_COORD_W-1:0]  center_x,
	input  logic [dvt_pkg::IN_COORD_W-1:0]  center_y,
	input  logic [dvt_pkg::RADIUS_W-1:0]    radius_q4,
	// result output
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [dvt_pkg::SLOT_OUT_W-1:0]  slot,
	output logic [1:0]                      outcome,
	output logic [dvt_pkg::VOTE_W-1:0]      vote_after,
	output logic                            confirmed,
	// threshold write
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dvt_pkg::VOTE_W-1:0]      cfg_data
);

	// input register
	logic              valid_s1;
	dvt_pkg::coord_t   cx_s1;
	dvt_pkg::coord_t   cy_s1;
	dvt_pkg::radius_t  rad_s1;

	// table
	dvt_pkg::coord_t   entry_x_q      [dvt_pkg::TABLE_SLOTS];
	dvt_pkg::coord_t   entry_y_q      [dvt_pkg::TABLE_SLOTS];
	dvt_pkg::radius_t  entry_radius_q [dvt_pkg::TABLE_SLOTS];
	dvt_pkg::vote_t    entry_vote_q   [dvt_pkg::TABLE_SLOTS];
	dvt_pkg::count_t   entry_count_q;

	dvt_pkg::vote_t    threshold_q;

	// output register
	logic              out_valid_q;
	logic [dvt_pkg::SLOT_OUT_W-1:0] slot_q;
	dvt_pkg::outcome_t outcome_q;
	dvt_pkg::vote_t    vote_q;
	logic              confirmed_q;

	// update path
	dvt_pkg::match_t   match;
	logic              out_free;
	logic              advance;
	logic              full;
	dvt_pkg::slot_idx_t fill_idx;
	dvt_pkg::vote_t    vote_cur;
	dvt_pkg::vote_t    vote_inc;
	logic              do_vote;
	logic              do_add;

	// handshakes
	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign cfg_ready = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cx_s1  <= dvt_pkg::COORD_BITS'(center_x);
			cy_s1  <= dvt_pkg::COORD_BITS'(center_y);
			rad_s1 <= radius_q4;
		end
	end

	// window search over the table
	dvt_match u_match (
		.entry_x      (entry_x_q),
		.entry_y      (entry_y_q),
		.entry_radius (entry_radius_q),
		.entry_count  (entry_count_q),
		.det_x        (cx_s1),
		.det_y        (cy_s1),
		.match        (match)
	);

	// vote and append decisions
	assign full     = entry_count_q == dvt_pkg::CNT_FULL;
	assign fill_idx = entry_count_q[dvt_pkg::SLOT_W-1:0];
	assign vote_cur = entry_vote_q[match.idx];
	assign vote_inc = (vote_cur == dvt_pkg::VOTE_MAX) ? vote_cur : vote_cur + 1'b1;
	assign do_vote  = advance && match.hit;
	assign do_add   = advance && !match.hit && !full;

	// table payload
	always_ff @(posedge clk) begin
		if (do_vote) begin
			entry_vote_q[match.idx] <= vote_inc;
		end
		if (do_add) begin
			entry_x_q[fill_idx]      <= cx_s1;
			entry_y_q[fill_idx]      <= cy_s1;
			entry_radius_q[fill_idx] <= rad_s1;
			entry_vote_q[fill_idx]   <= '0;
		end
	end

	// fill count and threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			threshold_q   <= dvt_pkg::THRESHOLD_INIT;
		end else begin
			if (do_add) begin
				entry_count_q <= entry_count_q + 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				threshold_q <= cfg_data;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			priority if (match.hit) begin
				slot_q      <= dvt_pkg::SLOT_OUT_W'(match.idx);
				outcome_q   <= dvt_pkg::OUTCOME_VOTED;
				vote_q      <= vote_inc;
				confirmed_q <= vote_inc > threshold_q;
			end else if (!full) begin
				slot_q      <= dvt_pkg::SLOT_OUT_W'(fill_idx);
				outcome_q   <= dvt_pkg::OUTCOME_ADDED;
				vote_q      <= '0;
				confirmed_q <= 1'b0;
			end else begin
				slot_q      <= '0;
				outcome_q   <= dvt_pkg::OUTCOME_DROPPED;
				vote_q      <= '0;
				confirmed_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign slot       = slot_q;
	assign outcome    = outcome_q;
	assign vote_after = vote_q;
	assign confirmed  = confirmed_q;

	// checks

	// fill count never runs past the table
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= dvt_pkg::CNT_FULL)
		else $error("entry count beyond table size");

	// an unmatched detection with room left grows the table by one
	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		do_add |=> entry_count_q == $past(entry_count_q) + 1'b1)
		else $error("append did not bump entry count");

	// only a voted-up entry can be confirmed
	a_confirm_voted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && confirmed_q |-> outcome_q == dvt_pkg::OUTCOME_VOTED)
		else $error("confirmed result without a vote");

	// a dropped detection only when the table was full
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !match.hit |-> full || do_add)
		else $error("detection dropped with room in table");

	// table is untouched while the result register holds
	a_hold_table: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> entry_count_q == $past(entry_count_q))
		else $error("table changed during output stall");

endmodule

>>> hw/rtl/dvt_match.sv
// parallel window compare of one detection against every live table entry
// picks the highest-indexed hit; depends on dvt_pkg
module dvt_match (
	input  dvt_pkg::coord_t  entry_x      [dvt_pkg::TABLE_SLOTS],
	input  dvt_pkg::coord_t  entry_y      [dvt_pkg::TABLE_SLOTS],
	input  dvt_pkg::radius_t entry_radius [dvt_pkg::TABLE_SLOTS],
	input  dvt_pkg::count_t  entry_count,
	input  dvt_pkg::coord_t  det_x,
	input  dvt_pkg::coord_t  det_y,
	output dvt_pkg::match_t  match
);

	logic [dvt_pkg::TABLE_SLOTS-1:0] hit_vec;
	logic [dvt_pkg::CMP_W-1:0]       dx;
	logic [dvt_pkg::CMP_W-1:0]       dy;

	// detection centre scaled to q.4
	assign dx = dvt_pkg::CMP_W'({det_x, 4'b0000});
	assign dy = dvt_pkg::CMP_W'({det_y, 4'b0000});

	// one compare lane per entry, strict square window on both axes
	for (genvar g = 0; g < dvt_pkg::TABLE_SLOTS; g++) begin : g_lane
		logic [dvt_pkg::CMP_W-1:0] ex;
		logic [dvt_pkg::CMP_W-1:0] ey;
		logic [dvt_pkg::CMP_W-1:0] r;
		logic                      live;
		logic                      in_x;
		logic                      in_y;

		assign ex   = dvt_pkg::CMP_W'({entry_x[g], 4'b0000});
		assign ey   = dvt_pkg::CMP_W'({entry_y[g], 4'b0000});
		assign r    = dvt_pkg::CMP_W'(entry_radius[g]);
		assign live = dvt_pkg::count_t'(g) < entry_count;
		assign in_x = (ex < dx + r) && (dx < ex + r);
		assign in_y = (ey < dy + r) && (dy < ey + r);
		assign hit_vec[g] = live && in_x && in_y;
	end

	// highest index wins
	always_comb begin
		match.hit = 1'b0;
		match.idx = '0;
		for (int i = 0; i < dvt_pkg::TABLE_SLOTS; i++) begin
			if (hit_vec[i]) begin
				match.hit = 1'b1;
				match.idx = dvt_pkg::slot_idx_t'(i);
			end
		end
	end

endmodule

>>> test/tb_detection_vote_table_top.sv
// testbench for detection_vote_table_top: directed table walk, threshold run and random traffic
// keeps its own copy of the light table to predict each result word; needs dvt_pkg and the rtl
module tb_detection_vote_table_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS    = 90;
	localparam int PLAN_ROWS      = 24;
	localparam int COORD_TOP      = (1 << dvt_pkg::COORD_BITS) - 1;

	// one expected result word
	typedef struct packed {
		logic [dvt_pkg::SLOT_OUT_W-1:0] slot;
		dvt_pkg::outcome_t              outcome;
		dvt_pkg::vote_t                 vote;
		logic                           confirmed;
	} verdict_t;

	// one row of the directed plan
	typedef struct packed {
		dvt_pkg::coord_t  cx;
		dvt_pkg::coord_t  cy;
		dvt_pkg::radius_t r;
		int               reps;
		bit               typed;
		verdict_t         want;
	} det_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic [dvt_pkg::IN_COORD_W-1:0] center_x;
	logic [dvt_pkg::IN_COORD_W-1:0] center_y;
	logic [dvt_pkg::RADIUS_W-1:0]   radius_q4;
	logic                           out_valid;
	logic                           out_stall;
	logic [dvt_pkg::SLOT_OUT_W-1:0] slot;
	logic [1:0]                     outcome;
	logic [dvt_pkg::VOTE_W-1:0]     vote_after;
	logic                           confirmed;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [dvt_pkg::VOTE_W-1:0]     cfg_data;

	// predicted table of tracked lights
	dvt_pkg::coord_t  lamp_x [dvt_pkg::TABLE_SLOTS];
	dvt_pkg::coord_t  lamp_y [dvt_pkg::TABLE_SLOTS];
	dvt_pkg::radius_t lamp_radius [dvt_pkg::TABLE_SLOTS];
	dvt_pkg::vote_t   lamp_votes [dvt_pkg::TABLE_SLOTS];
	int               lamp_count;
	dvt_pkg::vote_t   confirm_level;

	verdict_t pending_verdicts [$];
	det_row_t plan [PLAN_ROWS];

	int send_idle_pct;
	int recv_stall_pct;
	int idle_cycles;
	int error_count;
	int sent_count;
	int checked_count;
	int voted_count;
	int added_count;
	int dropped_count;
	int confirmed_count;

	detection_vote_table_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.center_x   (center_x),
		.center_y   (center_y),
		.radius_q4  (radius_q4),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.slot       (slot),
		.outcome    (outcome),
		.vote_after (vote_after),
		.confirmed  (confirmed),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// strict inside test on one axis, all in q.4
	function automatic bit axis_hit(dvt_pkg::coord_t centre, dvt_pkg::coord_t probe,
	                                dvt_pkg::radius_t r);
		int unsigned e;
		int unsigned d;
		e = int'(centre) * 16;
		d = int'(probe) * 16;
		return (e < d + r) && (d < e + r);
	endfunction

	// match a detection against the table, vote or append, and give the result word
	function automatic verdict_t track_detection(dvt_pkg::coord_t cx, dvt_pkg::coord_t cy,
	                                             dvt_pkg::radius_t r);
		verdict_t v;
		bit       found;
		v.slot      = '0;
		v.outcome   = dvt_pkg::OUTCOME_DROPPED;
		v.vote      = '0;
		v.confirmed = 1'b0;
		found       = 1'b0;
		for (int k = dvt_pkg::TABLE_SLOTS - 1; k >= 0; k--) begin
			if (!found && k < lamp_count && axis_hit(lamp_x[k], cx, lamp_radius[k]) &&
			    axis_hit(lamp_y[k], cy, lamp_radius[k])) begin
				if (lamp_votes[k] != dvt_pkg::VOTE_MAX)
					lamp_votes[k] = lamp_votes[k] + 1'b1;
				v.slot    = dvt_pkg::SLOT_OUT_W'(k);
				v.vote    = lamp_votes[k];
				v.outcome = dvt_pkg::OUTCOME_VOTED;
				found     = 1'b1;
			end
		end
		if (!found && lamp_count < dvt_pkg::TABLE_SLOTS) begin
			lamp_x[lamp_count]      = cx;
			lamp_y[lamp_count]      = cy;
			lamp_radius[lamp_count] = r;
			lamp_votes[lamp_count]  = '0;
			v.slot                  = dvt_pkg::SLOT_OUT_W'(lamp_count);
			v.outcome               = dvt_pkg::OUTCOME_ADDED;
			lamp_count              = lamp_count + 1;
		end
		v.confirmed = (v.outcome != dvt_pkg::OUTCOME_DROPPED) && (v.vote > confirm_level);
		return v;
	endfunction

	function automatic dvt_pkg::coord_t fold_coord(int v);
		if (v < 0)
			return '0;
		if (v > COORD_TOP)
			return dvt_pkg::coord_t'(COORD_TOP);
		return dvt_pkg::coord_t'(v);
	endfunction

	// drive one detection word from a falling edge, return at the falling edge after it is taken
	task automatic send_detection(dvt_pkg::coord_t cx, dvt_pkg::coord_t cy, dvt_pkg::radius_t r,
	                              bit typed, verdict_t want);
		verdict_t got;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		center_x  <= cx;
		center_y  <= cy;
		radius_q4 <= r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		got = track_detection(cx, cy, r);
		pending_verdicts.insert(pending_verdicts.size(), typed ? want : got);
		sent_count++;
		@(negedge clk);
	endtask

	// random detection: mostly close to a tracked light, some anywhere, some on the borders
	task automatic send_random_detection();
		int               roll;
		int               k;
		int               span;
		dvt_pkg::coord_t  cx;
		dvt_pkg::coord_t  cy;
		dvt_pkg::radius_t r;
		roll = $urandom_range(0, 99);
		r    = dvt_pkg::radius_t'($urandom);
		if (roll < 70) begin
			k    = $urandom_range(0, lamp_count - 1);
			span = int'(lamp_radius[k] >> 4) + 1;
			cx   = fold_coord(int'(lamp_x[k]) + int'($urandom_range(0, 2 * span)) - span);
			cy   = fold_coord(int'(lamp_y[k]) + int'($urandom_range(0, 2 * span)) - span);
		end else if (roll < 90) begin
			cx = dvt_pkg::coord_t'($urandom);
			cy = dvt_pkg::coord_t'($urandom);
		end else begin
			cx = $urandom_range(0, 1) ? dvt_pkg::coord_t'(COORD_TOP) : '0;
			cy = $urandom_range(0, 1) ? dvt_pkg::coord_t'(COORD_TOP) : '0;
			r  = $urandom_range(0, 1) ? dvt_pkg::VOTE_MAX : '0;
		end
		send_detection(cx, cy, r, 1'b0, '0);
	endtask

	// hold the sender off until every expected word is back
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_threshold(dvt_pkg::vote_t level);
		cfg_valid <= 1'b1;
		cfg_data  <= level;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		confirm_level = level;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// receiver stall
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				$error("result word with nothing expected: slot %0d outcome %0d vote %0d",
				       slot, outcome, vote_after);
				error_count++;
			end else begin
				want = pending_verdicts.pop_front();
				checked_count++;
				if (slot !== want.slot) begin
					$error("slot: expected %0d, got %0d", want.slot, slot);
					error_count++;
				end
				if (outcome !== want.outcome) begin
					$error("outcome: expected %0d, got %0d", want.outcome, outcome);
					error_count++;
				end
				if (vote_after !== want.vote) begin
					$error("vote_after: expected %0d, got %0d", want.vote, vote_after);
					error_count++;
				end
				if (confirmed !== want.confirmed) begin
					$error("confirmed: expected %0d, got %0d", want.confirmed, confirmed);
					error_count++;
				end
				case (want.outcome)
					dvt_pkg::OUTCOME_VOTED: voted_count++;
					dvt_pkg::OUTCOME_ADDED: added_count++;
					default: dropped_count++;
				endcase
				if (want.confirmed)
					confirmed_count++;
			end
		end
	end

	// watchdog on cycles with no word taken on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d idle cycles, %0d words outstanding",
			         idle_cycles, pending_verdicts.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// main sequence
	initial begin
		in_valid        = 1'b0;
		center_x        = '0;
		center_y        = '0;
		radius_q4       = '0;
		out_stall       = 1'b0;
		cfg_valid       = 1'b0;
		cfg_data        = '0;
		arst_n          = 1'b0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		idle_cycles     = 0;
		error_count     = 0;
		sent_count      = 0;
		checked_count   = 0;
		voted_count     = 0;
		added_count     = 0;
		dropped_count   = 0;
		confirmed_count = 0;
		lamp_count      = 0;
		confirm_level   = dvt_pkg::THRESHOLD_INIT;
		for (int k = 0; k < dvt_pkg::TABLE_SLOTS; k++) begin
			lamp_x[k]      = '0;
			lamp_y[k]      = '0;
			lamp_radius[k] = '0;
			lamp_votes[k]  = '0;
		end

		// directed plan, threshold left at its reset value
		plan = '{
			'{12'd100, 12'd100, 16'd160, 1, 1'b1, '{4'd0, dvt_pkg::OUTCOME_ADDED, 16'd0, 1'b0}},
			'{12'd109, 12'd91, 16'd160, 1, 1'b1, '{4'd0, dvt_pkg::OUTCOME_VOTED, 16'd1, 1'b0}},
			// on the edge of slot 0, zero radius entry
			'{12'd110, 12'd100, 16'd0, 1, 1'b1, '{4'd1, dvt_pkg::OUTCOME_ADDED, 16'd0, 1'b0}},
			'{12'd110, 12'd100, 16'd0, 1, 1'b1, '{4'd2, dvt_pkg::OUTCOME_ADDED, 16'd0, 1'b0}},
			'{12'd100, 12'd90, 16'd32, 1, 1'b1, '{4'd3, dvt_pkg::OUTCOME_ADDED, 16'd0, 1'b0}},
			// vote slot 0 up past the confirmation threshold
			'{12'd100, 12'd100, 16'd16, 50, 1'b0, '{4'd0, dvt_pkg::OUTCOME_VOTED, 16'd0, 1'b0}},
			'{12'd100, 12'd100, 16'd16, 1, 1'b1, '{4'd0, dvt_pkg::OUTCOME_VOTED, 16'd52, 1'b1}},
			// corners
			'{12'd0, 12'd0, 16'd16, 1, 1'b1, '{4'd4, dvt_pkg::OUTCOME_ADDED, 16'd0, 1'b0}},
			'{12'd4095, 12'd4095, 16'd16, 1, 1'b1, '{4'd5, dvt_pkg::OUTCOME_ADDED, 16'd0, 1'b0}},
			'{12'd0, 12'd4095, 16'd16, 1, 1'b1, '{4'd6, dvt_pkg::OUTCOME_ADDED, 16'd0, 1'b0}},
			'{12'd4095, 12'd0, 16'd16, 1, 1'b1, '{4'd7, dvt_pkg::OUTCOME_ADDED, 16'd0, 1'b0}},
			'{12'd4095, 12'd4095, 16'hFFFF, 1, 1'b1,
			  '{4'd5, dvt_pkg::OUTCOME_VOTED, 16'd1, 1'b0}},
			// two overlapping entries, highest slot wins
			'{12'd200, 12'd200, 16'd320, 1, 1'b1, '{4'd8, dvt_pkg::OUTCOME_ADDED, 16'd0, 1'b0}},
			'{12'd221, 12'd200, 16'd320, 1, 1'b1, '{4'd9, dvt_pkg::OUTCOME_ADDED, 16'd0, 1'b0}},
			'{12'd210, 12'd200, 16'd48, 1, 1'b1, '{4'd9, dvt_pkg::OUTCOME_VOTED, 16'd1, 1'b0}},
			'{12'd199, 12'd200, 16'd0, 1, 1'b1, '{4'd8, dvt_pkg::OUTCOME_VOTED, 16'd1, 1'b0}},
			// fill the rest of the table
			'{12'd1000, 12'd1000, 16'd80, 1, 1'b1, '{4'd10, dvt_pkg::OUTCOME_ADDED, 16'd0, 1'b0}},
			'{12'd2000, 12'd1000, 16'd80, 1, 1'b1, '{4'd11, dvt_pkg::OUTCOME_ADDED, 16'd0, 1'b0}},
			'{12'd3000, 12'd1000, 16'd80, 1, 1'b1, '{4'd12, dvt_pkg::OUTCOME_ADDED, 16'd0, 1'b0}},
			'{12'd1000, 12'd3000, 16'd80, 1, 1'b1, '{4'd13, dvt_pkg::OUTCOME_ADDED, 16'd0, 1'b0}},
			'{12'd2000, 12'd3000, 16'd80, 1, 1'b1, '{4'd14, dvt_pkg::OUTCOME_ADDED, 16'd0, 1'b0}},
			'{12'd3000, 12'd3000, 16'd480, 1, 1'b1,
			  '{4'd15, dvt_pkg::OUTCOME_ADDED, 16'd0, 1'b0}},
			// table full: no match is dropped
			'{12'd2500, 12'd2500, 16'hFFFF, 1, 1'b1,
			  '{4'd0, dvt_pkg::OUTCOME_DROPPED, 16'd0, 1'b0}},
			'{12'd3029, 12'd2971, 16'd0, 1, 1'b1, '{4'd15, dvt_pkg::OUTCOME_VOTED, 16'd1, 1'b0}}
		};

		// reset
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed walk, back to back
		for (int i = 0; i < PLAN_ROWS; i++) begin
			for (int n = 0; n < plan[i].reps; n++)
				send_detection(plan[i].cx, plan[i].cy, plan[i].r, plan[i].typed, plan[i].want);
		end

		// random phases, each with its own threshold and idling
		for (int p = 0; p < 4; p++) begin
			wait_for_results();
			case (p)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					write_threshold('0);
				end
				1: begin
					send_idle_pct  = 61;
					recv_stall_pct = 0;
					write_threshold(dvt_pkg::VOTE_MAX);
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 61;
					write_threshold(dvt_pkg::vote_t'($urandom_range(2, 12)));
				end
				default: begin
					send_idle_pct  = 28;
					recv_stall_pct = 28;
					write_threshold(dvt_pkg::VOTE_MAX - 1'b1);
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// let the output side empty completely once mid-stream
				if (p == 2 && i == PHASE_ITEMS / 2)
					wait_for_results();
				send_random_detection();
			end
		end

		// drain and a short hold for anything stray
		wait_for_results();
		recv_stall_pct = 0;
		repeat (4) @(posedge clk);

		$display("sent %0d detections, checked %0d result words", sent_count, checked_count);
		$display("outcomes: %0d voted, %0d added, %0d dropped; %0d confirmed",
		         voted_count, added_count, dropped_count, confirmed_count);
		if (error_count == 0 && pending_verdicts.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
